// ----- sv/lqrs_pkg.sv -----
// Shared types and constants for the linear / quadratic root solver.
// Used by every module of the block; no dependencies.
package lqrs_pkg;

  localparam int COEF_W  = 16;
  localparam int ROOT_W  = 32;
  localparam int DISC_W  = 35;
  localparam int PROD_W  = 2 * COEF_W;
  localparam int NQ_W    = COEF_W + 1;
  localparam int RAD_W   = 50;
  localparam int SQRT_W  = RAD_W / 2;
  localparam int SREM_W  = SQRT_W + 3;
  localparam int NUM_W   = 35;
  localparam int NMAG_W  = NUM_W - 1;
  localparam int DMAG_W  = NQ_W;
  localparam int SUM_W   = 27;
  localparam int FRAC_UP = 8;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_INFINITE = 3'd1,
    KIND_SINGLE   = 3'd2,
    KIND_DOUBLE   = 3'd3,
    KIND_TWO      = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [NQ_W-1:0]   nq;
    logic signed [NQ_W-1:0]   den;
    logic signed [DISC_W-1:0] disc;
  } ctl_t;

endpackage

// ----- sv/linear_quadratic_root_solver.sv -----
// Top level of the linear / quadratic root solver stream block.
// Instantiates lqrs_front, lqrs_sqrt and lqrs_div; uses lqrs_pkg.
//
// Usage:
//   Input beats arrive on s_axis: tdata carries coef_a, coef_b, coef_c
//   (signed Q8.8), tuser carries operation (0 linear, 1 quadratic).
//   Each input beat yields exactly one output beat on m_axis, in order:
//   tdata carries root_one, root_two (Q16.16) and the discriminant,
//   tuser carries root_kind and the saturated flag.
//   Throughput: one beat per cycle while the output is not stalled. An
//   input beat passes through 2 front stages (products, discriminant),
//   25 square-root stages, 1 numerator stage, 34 divider stages and
//   1 clip/output stage on its way to output valid.
//   Reset (rst, synchronous) empties the pipeline; s_axis_tready is high
//   right after reset.
//   When the receiver holds m_axis_tready low with a beat waiting, the
//   whole pipeline freezes and s_axis_tready drops in the same cycle;
//   nothing is lost or repeated, and it resumes when the beat is taken.
module linear_quadratic_root_solver (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [47:0]   s_axis_tdata,   // coef_a[15:0], coef_b[31:16], coef_c[47:32]
  input  logic [0:0]    s_axis_tuser,   // operation[0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // root_one[31:0], root_two[63:32],
                                        // discriminant[98:64], zero[103:99]
  output logic [3:0]    m_axis_tuser    // root_kind[2:0], saturated[3]
);

  logic                                   adv;
  logic                                   fv, sv;
  lqrs_pkg::ctl_t                         fctl, sctl;
  logic [lqrs_pkg::RAD_W-1:0]             rad;
  logic [lqrs_pkg::SQRT_W-1:0]            root;
  lqrs_pkg::kind_t                        kind;
  logic signed [lqrs_pkg::ROOT_W-1:0]     r1, r2;
  logic signed [lqrs_pkg::DISC_W-1:0]     disc;
  logic                                   sat;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  lqrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_axis_tvalid),
    .op        (s_axis_tuser[0]),
    .a         (s_axis_tdata[15:0]),
    .b         (s_axis_tdata[31:16]),
    .c         (s_axis_tdata[47:32]),
    .out_valid (fv),
    .ctl       (fctl),
    .rad       (rad)
  );

  lqrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (fv),
    .in_ctl    (fctl),
    .rad       (rad),
    .out_valid (sv),
    .out_ctl   (sctl),
    .root      (root)
  );

  lqrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sv),
    .in_ctl    (sctl),
    .root      (root),
    .out_valid (m_axis_tvalid),
    .kind      (kind),
    .root_one  (r1),
    .root_two  (r2),
    .disc      (disc),
    .saturated (sat)
  );

  assign m_axis_tdata = {5'b0, disc, r2, r1};
  assign m_axis_tuser = {sat, kind};

endmodule

// ----- sv/lqrs_front.sv -----
// Front end: coefficient products, discriminant and classification.
// Two register stages. Depends on lqrs_pkg.
module lqrs_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic                                  op,
  input  logic signed [lqrs_pkg::COEF_W-1:0]    a,
  input  logic signed [lqrs_pkg::COEF_W-1:0]    b,
  input  logic signed [lqrs_pkg::COEF_W-1:0]    c,
  output logic                                  out_valid,
  output lqrs_pkg::ctl_t                        ctl,
  output logic [lqrs_pkg::RAD_W-1:0]            rad
);

  logic                                  va;
  logic                                  op_a;
  logic signed [lqrs_pkg::COEF_W-1:0]    a_a, b_a, c_a;
  logic signed [lqrs_pkg::PROD_W-1:0]    bb_a, ac_a;

  lqrs_pkg::ctl_t                        ctl_next;
  logic [lqrs_pkg::RAD_W-1:0]            rad_next;
  logic signed [lqrs_pkg::DISC_W-1:0]    d;
  logic signed [lqrs_pkg::COEF_W-1:0]    p, q;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
      out_valid <= va;
    end
    if (adv) begin
      op_a <= op;
      a_a  <= a;
      b_a  <= b;
      c_a  <= c;
      bb_a <= b * b;
      ac_a <= a * c;
      ctl  <= ctl_next;
      rad  <= rad_next;
    end
  end

  always_comb begin
    d = lqrs_pkg::DISC_W'(bb_a) - (lqrs_pkg::DISC_W'(ac_a) <<< 2);
    p = op_a ? b_a : a_a;
    q = op_a ? c_a : b_a;
    ctl_next.kind = lqrs_pkg::KIND_NONE;
    ctl_next.nq   = '0;
    ctl_next.den  = lqrs_pkg::NQ_W'(1);
    ctl_next.disc = '0;
    rad_next      = '0;
    if (!op_a || a_a == '0) begin
      if (p == '0) begin
        ctl_next.kind = (q == '0) ? lqrs_pkg::KIND_INFINITE : lqrs_pkg::KIND_NONE;
      end else begin
        ctl_next.kind = lqrs_pkg::KIND_SINGLE;
        ctl_next.nq   = -lqrs_pkg::NQ_W'(q);
        ctl_next.den  = lqrs_pkg::NQ_W'(p);
      end
    end else begin
      ctl_next.disc = d;
      ctl_next.nq   = -lqrs_pkg::NQ_W'(b_a);
      ctl_next.den  = lqrs_pkg::NQ_W'(a_a) <<< 1;
      if (d[lqrs_pkg::DISC_W-1]) begin
        ctl_next.kind = lqrs_pkg::KIND_NONE;
      end else if (d == '0) begin
        ctl_next.kind = lqrs_pkg::KIND_DOUBLE;
      end else begin
        ctl_next.kind = lqrs_pkg::KIND_TWO;
        rad_next = {d[lqrs_pkg::RAD_W-17:0], 16'b0};
      end
    end
  end

endmodule

// ----- sv/lqrs_sqrt.sv -----
// Pipelined floor square root, one result bit per register stage.
// Carries the item's control word alongside. Depends on lqrs_pkg.
module lqrs_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  lqrs_pkg::ctl_t                    in_ctl,
  input  logic [lqrs_pkg::RAD_W-1:0]        rad,
  output logic                              out_valid,
  output lqrs_pkg::ctl_t                    out_ctl,
  output logic [lqrs_pkg::SQRT_W-1:0]       root
);

  localparam int N = lqrs_pkg::SQRT_W;

  logic                              v    [N];
  lqrs_pkg::ctl_t                    cw   [N];
  logic [lqrs_pkg::RAD_W-1:0]        rd   [N];
  logic [lqrs_pkg::SREM_W-1:0]       rm   [N];
  logic [lqrs_pkg::SQRT_W-1:0]       rs   [N];

  logic [lqrs_pkg::RAD_W-1:0]        rd_next [N];
  logic [lqrs_pkg::SREM_W-1:0]       rm_next [N];
  logic [lqrs_pkg::SQRT_W-1:0]       rs_next [N];

  always_comb begin
    logic [lqrs_pkg::RAD_W-1:0]  rd_in;
    logic [lqrs_pkg::SREM_W-1:0] rm_in;
    logic [lqrs_pkg::SQRT_W-1:0] rs_in;
    logic [lqrs_pkg::SREM_W-1:0] rt;
    logic [lqrs_pkg::SREM_W-1:0] tr;
    for (int k = 0; k < N; k++) begin
      rd_in = (k == 0) ? rad : rd[(k == 0) ? 0 : k - 1];
      rm_in = (k == 0) ? '0  : rm[(k == 0) ? 0 : k - 1];
      rs_in = (k == 0) ? '0  : rs[(k == 0) ? 0 : k - 1];
      rt = {rm_in[lqrs_pkg::SREM_W-3:0], rd_in[lqrs_pkg::RAD_W-1 -: 2]};
      tr = {1'b0, rs_in, 2'b01};
      rd_next[k] = rd_in << 2;
      if (rt >= tr) begin
        rm_next[k] = rt - tr;
        rs_next[k] = {rs_in[lqrs_pkg::SQRT_W-2:0], 1'b1};
      end else begin
        rm_next[k] = rt;
        rs_next[k] = {rs_in[lqrs_pkg::SQRT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) v[k] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
      for (int k = 1; k < N; k++) v[k] <= v[k-1];
    end
    if (adv) begin
      cw[0] <= in_ctl;
      for (int k = 1; k < N; k++) cw[k] <= cw[k-1];
      for (int k = 0; k < N; k++) begin
        rd[k] <= rd_next[k];
        rm[k] <= rm_next[k];
        rs[k] <= rs_next[k];
      end
    end
  end

  assign out_valid = v[N-1];
  assign out_ctl   = cw[N-1];
  assign root      = rs[N-1];

endmodule

// ----- sv/lqrs_div.sv -----
// Back end: numerator forming, two-lane pipelined restoring divider,
// sign restore, clipping and result register. Depends on lqrs_pkg.
module lqrs_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  lqrs_pkg::ctl_t                        in_ctl,
  input  logic [lqrs_pkg::SQRT_W-1:0]           root,
  output logic                                  out_valid,
  output lqrs_pkg::kind_t                       kind,
  output logic signed [lqrs_pkg::ROOT_W-1:0]    root_one,
  output logic signed [lqrs_pkg::ROOT_W-1:0]    root_two,
  output logic signed [lqrs_pkg::DISC_W-1:0]    disc,
  output logic                                  saturated
);

  localparam int N = lqrs_pkg::NMAG_W;

  typedef struct packed {
    lqrs_pkg::kind_t                    kind;
    logic signed [lqrs_pkg::DISC_W-1:0] disc;
    logic                               neg1;
    logic                               neg2;
    logic [lqrs_pkg::DMAG_W-1:0]        dm;
  } side_t;

  // numerator stage
  logic                              vf;
  side_t                             sf;
  logic [lqrs_pkg::NMAG_W-1:0]       nf1, nf2;

  side_t                             sf_next;
  logic signed [lqrs_pkg::SUM_W-1:0] base, sum1, sum2;
  logic signed [lqrs_pkg::NUM_W-1:0] n1, n2;

  always_comb begin
    base = lqrs_pkg::SUM_W'(in_ctl.nq) <<< lqrs_pkg::FRAC_UP;
    sum1 = base + $signed(lqrs_pkg::SUM_W'(root));
    sum2 = base - $signed(lqrs_pkg::SUM_W'(root));
    n1 = lqrs_pkg::NUM_W'(sum1) <<< lqrs_pkg::FRAC_UP;
    n2 = lqrs_pkg::NUM_W'(sum2) <<< lqrs_pkg::FRAC_UP;
    sf_next.kind = in_ctl.kind;
    sf_next.disc = in_ctl.disc;
    sf_next.neg1 = n1[lqrs_pkg::NUM_W-1] ^ in_ctl.den[lqrs_pkg::NQ_W-1];
    sf_next.neg2 = n2[lqrs_pkg::NUM_W-1] ^ in_ctl.den[lqrs_pkg::NQ_W-1];
    sf_next.dm   = in_ctl.den[lqrs_pkg::NQ_W-1] ? lqrs_pkg::DMAG_W'(-in_ctl.den)
                                                : lqrs_pkg::DMAG_W'(in_ctl.den);
  end

  // divider stages
  logic                              v  [N];
  side_t                             sd [N];
  logic [lqrs_pkg::NMAG_W-1:0]       na [N], nb [N];
  logic [lqrs_pkg::DMAG_W-1:0]       ra [N], rb [N];
  logic [lqrs_pkg::NMAG_W-1:0]       qa [N], qb [N];

  logic [lqrs_pkg::NMAG_W-1:0]       na_next [N], nb_next [N];
  logic [lqrs_pkg::DMAG_W-1:0]       ra_next [N], rb_next [N];
  logic [lqrs_pkg::NMAG_W-1:0]       qa_next [N], qb_next [N];

  always_comb begin
    logic [lqrs_pkg::NMAG_W-1:0] ni1, ni2, qi1, qi2;
    logic [lqrs_pkg::DMAG_W-1:0] ri1, ri2, dmi;
    logic [lqrs_pkg::DMAG_W:0]   t1, t2;
    for (int k = 0; k < N; k++) begin
      ni1 = (k == 0) ? nf1 : na[(k == 0) ? 0 : k - 1];
      ni2 = (k == 0) ? nf2 : nb[(k == 0) ? 0 : k - 1];
      ri1 = (k == 0) ? '0  : ra[(k == 0) ? 0 : k - 1];
      ri2 = (k == 0) ? '0  : rb[(k == 0) ? 0 : k - 1];
      qi1 = (k == 0) ? '0  : qa[(k == 0) ? 0 : k - 1];
      qi2 = (k == 0) ? '0  : qb[(k == 0) ? 0 : k - 1];
      dmi = (k == 0) ? sf.dm : sd[(k == 0) ? 0 : k - 1].dm;
      t1 = {ri1, ni1[lqrs_pkg::NMAG_W-1]};
      t2 = {ri2, ni2[lqrs_pkg::NMAG_W-1]};
      na_next[k] = ni1 << 1;
      nb_next[k] = ni2 << 1;
      if (t1 >= {1'b0, dmi}) begin
        ra_next[k] = lqrs_pkg::DMAG_W'(t1 - {1'b0, dmi});
        qa_next[k] = {qi1[lqrs_pkg::NMAG_W-2:0], 1'b1};
      end else begin
        ra_next[k] = lqrs_pkg::DMAG_W'(t1);
        qa_next[k] = {qi1[lqrs_pkg::NMAG_W-2:0], 1'b0};
      end
      if (t2 >= {1'b0, dmi}) begin
        rb_next[k] = lqrs_pkg::DMAG_W'(t2 - {1'b0, dmi});
        qb_next[k] = {qi2[lqrs_pkg::NMAG_W-2:0], 1'b1};
      end else begin
        rb_next[k] = lqrs_pkg::DMAG_W'(t2);
        qb_next[k] = {qi2[lqrs_pkg::NMAG_W-2:0], 1'b0};
      end
    end
  end

  // sign restore and clip
  side_t                                 sl;
  logic signed [lqrs_pkg::NUM_W-1:0]     q1, q2;
  logic signed [lqrs_pkg::ROOT_W-1:0]    c1, c2;
  logic                                  s1, s2;
  logic signed [lqrs_pkg::ROOT_W-1:0]    r1_next, r2_next;
  logic                                  sat_next;

  localparam logic signed [lqrs_pkg::NUM_W-1:0] QMAX =
    lqrs_pkg::NUM_W'((64'sd1 <<< (lqrs_pkg::ROOT_W - 1)) - 64'sd1);
  localparam logic signed [lqrs_pkg::NUM_W-1:0] QMIN =
    lqrs_pkg::NUM_W'(-(64'sd1 <<< (lqrs_pkg::ROOT_W - 1)));

  always_comb begin
    sl = sd[N-1];
    q1 = $signed({1'b0, qa[N-1]});
    q2 = $signed({1'b0, qb[N-1]});
    if (sl.neg1) q1 = -q1;
    if (sl.neg2) q2 = -q2;
    s1 = 1'b0;
    s2 = 1'b0;
    c1 = lqrs_pkg::ROOT_W'(q1);
    c2 = lqrs_pkg::ROOT_W'(q2);
    if (q1 > QMAX) begin
      c1 = lqrs_pkg::ROOT_W'(QMAX); s1 = 1'b1;
    end else if (q1 < QMIN) begin
      c1 = lqrs_pkg::ROOT_W'(QMIN); s1 = 1'b1;
    end
    if (q2 > QMAX) begin
      c2 = lqrs_pkg::ROOT_W'(QMAX); s2 = 1'b1;
    end else if (q2 < QMIN) begin
      c2 = lqrs_pkg::ROOT_W'(QMIN); s2 = 1'b1;
    end
    r1_next  = '0;
    r2_next  = '0;
    sat_next = 1'b0;
    case (sl.kind)
      lqrs_pkg::KIND_SINGLE, lqrs_pkg::KIND_DOUBLE: begin
        r1_next  = c1;
        sat_next = s1;
      end
      lqrs_pkg::KIND_TWO: begin
        r1_next  = c1;
        r2_next  = c2;
        sat_next = s1 | s2;
      end
      default: begin
        r1_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
      for (int k = 0; k < N; k++) v[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vf <= in_valid;
      v[0] <= vf;
      for (int k = 1; k < N; k++) v[k] <= v[k-1];
      out_valid <= v[N-1];
    end
    if (adv) begin
      sf  <= sf_next;
      nf1 <= n1[lqrs_pkg::NUM_W-1] ? lqrs_pkg::NMAG_W'(-n1) : lqrs_pkg::NMAG_W'(n1);
      nf2 <= n2[lqrs_pkg::NUM_W-1] ? lqrs_pkg::NMAG_W'(-n2) : lqrs_pkg::NMAG_W'(n2);
      sd[0] <= sf;
      for (int k = 1; k < N; k++) sd[k] <= sd[k-1];
      for (int k = 0; k < N; k++) begin
        na[k] <= na_next[k];
        nb[k] <= nb_next[k];
        ra[k] <= ra_next[k];
        rb[k] <= rb_next[k];
        qa[k] <= qa_next[k];
        qb[k] <= qb_next[k];
      end
      kind      <= sl.kind;
      disc      <= sl.disc;
      root_one  <= r1_next;
      root_two  <= r2_next;
      saturated <= sat_next;
    end
  end

endmodule
